FILE: hw/rtl/pad_card_serial_port_macros.svh
// assertion macros for the pad and card serial port
// used by modules that check their own logic; no other dependencies
`ifndef PAD_CARD_SERIAL_PORT_MACROS_SVH
`define PAD_CARD_SERIAL_PORT_MACROS_SVH
`ifndef SYNTHESIS
`define PCSP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PCSP_NEVER(label, expr, msg) \
	`PCSP_ASSERT(label, !(expr), msg)
`else
`define PCSP_ASSERT(label, prop, msg)
`define PCSP_NEVER(label, expr, msg)
`endif
`endif

FILE: hw/rtl/pcsp_pkg.sv
// shared types and codes for the pad and card serial port
// no dependencies
package pcsp_pkg;

	typedef enum logic [2:0] {
		OP_WR_DATA   = 3'd0,
		OP_RD_DATA   = 3'd1,
		OP_WR_CTL    = 3'd2,
		OP_XFER_DONE = 3'd3,
		OP_ACK_DELAY = 3'd4,
		OP_ACK_LOW   = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_XFER = 2'd1,
		PH_ACKP = 2'd2,
		PH_ACKL = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		DEV_NONE = 2'd0,
		DEV_PAD  = 2'd1,
		DEV_CARD = 2'd2
	} dev_t;

	localparam logic [7:0] EMPTY_BYTE = 8'hff;

	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] tx_byte;
		logic       ctl_select;
		logic       ctl_tx_enable;
		logic       ctl_acknowledge;
		logic       ctl_reset;
		logic       ctl_ack_irq_enable;
		logic       ctl_slot;
		logic       pad_acked;
		logic [7:0] pad_reply;
		logic       card_acked;
		logic [7:0] card_reply;
	} req_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       rx_not_empty;
		logic       tx_ready_started;
		logic       tx_ready_finished;
		logic       ack_line_low;
		logic       irq_flag;
		logic       irq_raise;
		logic       transfer_start;
		logic [7:0] transfer_byte;
		logic       transfer_slot;
		logic [1:0] ack_wait_device;
		logic       deselect_pulse;
	} rsp_t;

endpackage

FILE: hw/rtl/pcsp_in_stage.sv
// request input register of the pad and card serial port
// uses pcsp_pkg
module pcsp_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  pcsp_pkg::req_t  req_data,
	input  logic            advance,
	output logic            valid_s1,
	output pcsp_pkg::req_t  req_s1
);

	assign req_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			req_s1 <= req_data;
		end
	end

endmodule

FILE: hw/rtl/pcsp_core.sv
// port state registers and per-request next-state logic
// uses pcsp_pkg and pad_card_serial_port_macros.svh
`include "pad_card_serial_port_macros.svh"
module pcsp_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  pcsp_pkg::req_t  req_s1,
	output pcsp_pkg::rsp_t  rsp
);

	logic [7:0]       tx_store_q, tx_store_n;
	logic             tx_full_q, tx_full_n;
	logic [7:0]       rx_store_q, rx_store_n;
	logic             rx_full_q, rx_full_n;
	logic [7:0]       shift_q, shift_n;
	pcsp_pkg::phase_t phase_q, phase_n;
	pcsp_pkg::dev_t   dev_q, dev_n;
	logic             sel_q, sel_n;
	logic             txen_q, txen_n;
	logic             irqen_q, irqen_n;
	logic             slot_q, slot_n;
	logic             irq_q, irq_n;
	logic             ack_low_q, ack_low_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_store_q <= '0;
			tx_full_q  <= 1'b0;
			rx_store_q <= '0;
			rx_full_q  <= 1'b0;
			shift_q    <= '0;
			phase_q    <= pcsp_pkg::PH_IDLE;
			dev_q      <= pcsp_pkg::DEV_NONE;
			sel_q      <= 1'b0;
			txen_q     <= 1'b0;
			irqen_q    <= 1'b0;
			slot_q     <= 1'b0;
			irq_q      <= 1'b0;
			ack_low_q  <= 1'b0;
		end else if (fire) begin
			tx_store_q <= tx_store_n;
			tx_full_q  <= tx_full_n;
			rx_store_q <= rx_store_n;
			rx_full_q  <= rx_full_n;
			shift_q    <= shift_n;
			phase_q    <= phase_n;
			dev_q      <= dev_n;
			sel_q      <= sel_n;
			txen_q     <= txen_n;
			irqen_q    <= irqen_n;
			slot_q     <= slot_n;
			irq_q      <= irq_n;
			ack_low_q  <= ack_low_n;
		end
	end

	always_comb begin
		logic       try_start;
		logic       started;
		logic       raise;
		logic       desel;
		logic       acked;
		logic [7:0] got;
		logic [7:0] rd;
		logic [1:0] wait_dev;
		tx_store_n = tx_store_q;
		tx_full_n  = tx_full_q;
		rx_store_n = rx_store_q;
		rx_full_n  = rx_full_q;
		shift_n    = shift_q;
		phase_n    = phase_q;
		dev_n      = dev_q;
		sel_n      = sel_q;
		txen_n     = txen_q;
		irqen_n    = irqen_q;
		slot_n     = slot_q;
		irq_n      = irq_q;
		ack_low_n  = ack_low_q;
		try_start  = 1'b0;
		started    = 1'b0;
		raise      = 1'b0;
		desel      = 1'b0;
		acked      = 1'b0;
		got        = pcsp_pkg::EMPTY_BYTE;
		rd         = '0;
		wait_dev   = pcsp_pkg::DEV_NONE;
		case (pcsp_pkg::op_t'(req_s1.operation))
			pcsp_pkg::OP_WR_DATA: begin
				tx_store_n = req_s1.tx_byte;
				tx_full_n  = 1'b1;
				try_start  = 1'b1;
			end
			pcsp_pkg::OP_RD_DATA: begin
				rd        = rx_full_q ? rx_store_q : pcsp_pkg::EMPTY_BYTE;
				rx_full_n = 1'b0;
			end
			pcsp_pkg::OP_WR_CTL: begin
				sel_n   = req_s1.ctl_select;
				txen_n  = req_s1.ctl_tx_enable;
				irqen_n = req_s1.ctl_ack_irq_enable;
				slot_n  = req_s1.ctl_slot;
				if (req_s1.ctl_reset) begin
					sel_n      = 1'b0;
					txen_n     = 1'b0;
					irqen_n    = 1'b0;
					slot_n     = 1'b0;
					irq_n      = 1'b0;
					ack_low_n  = 1'b0;
					tx_store_n = '0;
					tx_full_n  = 1'b0;
					rx_store_n = '0;
					rx_full_n  = 1'b0;
					phase_n    = pcsp_pkg::PH_IDLE;
				end
				if (req_s1.ctl_acknowledge) begin
					irq_n = 1'b0;
				end
				if (!sel_n) begin
					dev_n = pcsp_pkg::DEV_NONE;
					desel = 1'b1;
				end
				if (sel_n && txen_n) begin
					try_start = 1'b1;
				end else begin
					phase_n = pcsp_pkg::PH_IDLE;
				end
			end
			pcsp_pkg::OP_XFER_DONE: begin
				if (phase_q == pcsp_pkg::PH_XFER) begin
					case (dev_q)
						pcsp_pkg::DEV_NONE: begin
							if (req_s1.pad_acked) begin
								dev_n = pcsp_pkg::DEV_PAD;
								acked = 1'b1;
								got   = req_s1.pad_reply;
							end else if (req_s1.card_acked) begin
								dev_n = pcsp_pkg::DEV_CARD;
								acked = 1'b1;
								got   = req_s1.card_reply;
							end
						end
						pcsp_pkg::DEV_PAD: begin
							if (req_s1.pad_acked) begin
								acked = 1'b1;
								got   = req_s1.pad_reply;
							end else begin
								dev_n = pcsp_pkg::DEV_NONE;
							end
						end
						default: begin
							if (req_s1.card_acked) begin
								acked = 1'b1;
								got   = req_s1.card_reply;
							end else begin
								dev_n = pcsp_pkg::DEV_NONE;
							end
						end
					endcase
					rx_store_n = got;
					rx_full_n  = 1'b1;
					if (acked) begin
						phase_n  = pcsp_pkg::PH_ACKP;
						wait_dev = (dev_n == pcsp_pkg::DEV_PAD) ? pcsp_pkg::DEV_PAD
							: pcsp_pkg::DEV_CARD;
					end else begin
						ack_low_n = 1'b0;
						phase_n   = pcsp_pkg::PH_IDLE;
						try_start = 1'b1;
					end
				end
			end
			pcsp_pkg::OP_ACK_DELAY: begin
				if (phase_q == pcsp_pkg::PH_ACKP) begin
					ack_low_n = 1'b1;
					if (irqen_q) begin
						irq_n = 1'b1;
						raise = 1'b1;
					end
					phase_n = pcsp_pkg::PH_ACKL;
				end
			end
			pcsp_pkg::OP_ACK_LOW: begin
				if (phase_q == pcsp_pkg::PH_ACKL) begin
					ack_low_n = 1'b0;
					phase_n   = pcsp_pkg::PH_IDLE;
					try_start = 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (try_start && tx_full_n && sel_n && txen_n && phase_n == pcsp_pkg::PH_IDLE) begin
			shift_n   = tx_store_n;
			tx_full_n = 1'b0;
			phase_n   = pcsp_pkg::PH_XFER;
			started   = 1'b1;
		end
		rsp.read_byte         = rd;
		rsp.rx_not_empty      = rx_full_n;
		rsp.tx_ready_started  = !tx_full_n;
		rsp.tx_ready_finished = tx_full_n && phase_n != pcsp_pkg::PH_XFER;
		rsp.ack_line_low      = ack_low_n;
		rsp.irq_flag          = irq_n;
		rsp.irq_raise         = raise;
		rsp.transfer_start    = started;
		rsp.transfer_byte     = shift_n;
		rsp.transfer_slot     = slot_n;
		rsp.ack_wait_device   = wait_dev;
		rsp.deselect_pulse    = desel;
	end

	`PCSP_ASSERT(a_start_enters_xfer, fire && rsp.transfer_start |=> phase_q == pcsp_pkg::PH_XFER, "transfer start did not enter transfer phase")
	`PCSP_ASSERT(a_idle_holds_state, !fire |=> $stable(phase_q) && $stable(tx_full_q), "state changed without a request")
	`PCSP_ASSERT(a_raise_sets_flag, fire && rsp.irq_raise |=> irq_q, "interrupt raised but flag not set")
	`PCSP_NEVER(a_wait_only_from_xfer, fire && rsp.ack_wait_device != pcsp_pkg::DEV_NONE && phase_q != pcsp_pkg::PH_XFER, "ack wait begun outside transfer phase")

endmodule

FILE: hw/rtl/pcsp_out_stage.sv
// result register of the pad and card serial port
// uses pcsp_pkg
module pcsp_out_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_s1,
	input  pcsp_pkg::rsp_t  rsp,
	output logic            advance,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output pcsp_pkg::rsp_t  rsp_data
);

	pcsp_pkg::rsp_t rsp_s2;

	assign advance  = !rsp_valid || !rsp_stall;
	assign rsp_data = rsp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (advance) begin
			rsp_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			rsp_s2 <= rsp;
		end
	end

endmodule

FILE: hw/rtl/pad_card_serial_port.sv
// pad and card serial port, host side: top level
// an accepted request is held in the input register, and its result in the result register
// throughput: one request per cycle, limited only by the result register
// reset: arst_n clears buffers, phase, device, control bits and the valid bits of both registers
// uses pcsp_pkg, pcsp_in_stage, pcsp_core, pcsp_out_stage
module pad_card_serial_port (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  pcsp_pkg::req_t  req_data,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output pcsp_pkg::rsp_t  rsp_data
);

	logic           advance;
	logic           valid_s1;
	pcsp_pkg::req_t req_s1;
	pcsp_pkg::rsp_t rsp;

	pcsp_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.req_s1    (req_s1)
	);

	pcsp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (valid_s1 && advance),
		.req_s1 (req_s1),
		.rsp    (rsp)
	);

	pcsp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.rsp       (rsp),
		.advance   (advance),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

endmodule

FILE: verif/tb.sv
// testbench for pad_card_serial_port: drives requests over the valid/stall channel and checks
// every status result against a behavioral model of the port kept inside this file
// depends on pcsp_pkg and the rtl of pad_card_serial_port only
module tb;

	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	pcsp_pkg::req_t req_data = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	pcsp_pkg::rsp_t rsp_data;

	pad_card_serial_port dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	always #2 clk = ~clk;

	// port model state
	logic [7:0]       tx_hold = '0;
	logic             tx_loaded = 1'b0;
	logic [7:0]       rx_hold = '0;
	logic             rx_loaded = 1'b0;
	logic [7:0]       shift_reg = '0;
	pcsp_pkg::phase_t phase = pcsp_pkg::PH_IDLE;
	pcsp_pkg::dev_t   device = pcsp_pkg::DEV_NONE;
	logic             sel_bit = 1'b0;
	logic             txen_bit = 1'b0;
	logic             irqen_bit = 1'b0;
	logic             slot_bit = 1'b0;
	logic             irq_set = 1'b0;
	logic             ack_line = 1'b0;
	logic             started = 1'b0;

	pcsp_pkg::rsp_t status_due[$];
	int   mismatches = 0;
	int   errors = 0;

	bit gaps_on = 1'b0;
	bit stalls_on = 1'b0;
	int hold_id = 0;
	int hold_len = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int stall_left = 0;

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 24);
	endfunction

	task automatic begin_shift();
		if (tx_loaded && sel_bit && txen_bit && phase == pcsp_pkg::PH_IDLE) begin
			shift_reg = tx_hold;
			tx_loaded = 1'b0;
			phase = pcsp_pkg::PH_XFER;
			started = 1'b1;
		end
	endtask

	task automatic end_transfer();
		ack_line = 1'b0;
		phase = pcsp_pkg::PH_IDLE;
		begin_shift();
	endtask

	task automatic port_step(input pcsp_pkg::req_t r, output pcsp_pkg::rsp_t o);
		logic [7:0]     rd;
		logic [7:0]     got;
		logic           raise;
		logic           desel;
		logic           acked;
		pcsp_pkg::dev_t wait_dev;
		rd = '0;
		got = pcsp_pkg::EMPTY_BYTE;
		raise = 1'b0;
		desel = 1'b0;
		acked = 1'b0;
		wait_dev = pcsp_pkg::DEV_NONE;
		started = 1'b0;
		case (r.operation)
			pcsp_pkg::OP_WR_DATA: begin
				tx_hold = r.tx_byte;
				tx_loaded = 1'b1;
				begin_shift();
			end
			pcsp_pkg::OP_RD_DATA: begin
				rd = pcsp_pkg::EMPTY_BYTE;
				if (rx_loaded) begin
					rd = rx_hold;
					rx_loaded = 1'b0;
				end
			end
			pcsp_pkg::OP_WR_CTL: begin
				sel_bit = r.ctl_select;
				txen_bit = r.ctl_tx_enable;
				irqen_bit = r.ctl_ack_irq_enable;
				slot_bit = r.ctl_slot;
				if (r.ctl_reset) begin
					sel_bit = 1'b0;
					txen_bit = 1'b0;
					irqen_bit = 1'b0;
					slot_bit = 1'b0;
					irq_set = 1'b0;
					ack_line = 1'b0;
					tx_hold = '0;
					tx_loaded = 1'b0;
					rx_hold = '0;
					rx_loaded = 1'b0;
					phase = pcsp_pkg::PH_IDLE;
				end
				if (r.ctl_acknowledge)
					irq_set = 1'b0;
				if (!sel_bit) begin
					device = pcsp_pkg::DEV_NONE;
					desel = 1'b1;
				end
				if (sel_bit && txen_bit)
					begin_shift();
				else
					phase = pcsp_pkg::PH_IDLE;
			end
			pcsp_pkg::OP_XFER_DONE: begin
				if (phase == pcsp_pkg::PH_XFER) begin
					case (device)
						pcsp_pkg::DEV_NONE: begin
							if (r.pad_acked) begin
								device = pcsp_pkg::DEV_PAD;
								acked = 1'b1;
								got = r.pad_reply;
							end else if (r.card_acked) begin
								device = pcsp_pkg::DEV_CARD;
								acked = 1'b1;
								got = r.card_reply;
							end
						end
						pcsp_pkg::DEV_PAD: begin
							if (r.pad_acked) begin
								acked = 1'b1;
								got = r.pad_reply;
							end else
								device = pcsp_pkg::DEV_NONE;
						end
						default: begin
							if (r.card_acked) begin
								acked = 1'b1;
								got = r.card_reply;
							end else
								device = pcsp_pkg::DEV_NONE;
						end
					endcase
					rx_hold = got;
					rx_loaded = 1'b1;
					if (acked) begin
						phase = pcsp_pkg::PH_ACKP;
						wait_dev = device;
					end else
						end_transfer();
				end
			end
			pcsp_pkg::OP_ACK_DELAY: begin
				if (phase == pcsp_pkg::PH_ACKP) begin
					ack_line = 1'b1;
					if (irqen_bit) begin
						irq_set = 1'b1;
						raise = 1'b1;
					end
					phase = pcsp_pkg::PH_ACKL;
				end
			end
			pcsp_pkg::OP_ACK_LOW: begin
				if (phase == pcsp_pkg::PH_ACKL)
					end_transfer();
			end
			default: ;
		endcase
		o.read_byte = rd;
		o.rx_not_empty = rx_loaded;
		o.tx_ready_started = !tx_loaded;
		o.tx_ready_finished = tx_loaded && phase != pcsp_pkg::PH_XFER;
		o.ack_line_low = ack_line;
		o.irq_flag = irq_set;
		o.irq_raise = raise;
		o.transfer_start = started;
		o.transfer_byte = shift_reg;
		o.transfer_slot = slot_bit;
		o.ack_wait_device = wait_dev;
		o.deselect_pulse = desel;
	endtask

	// sender: optional gap, then offer until accepted; valid stays high into the next call
	task automatic send_request(input pcsp_pkg::req_t r);
		int             gap;
		pcsp_pkg::rsp_t want;
		gap = gaps_on ? idle_len() : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		do
			@(posedge clk);
		while (req_stall);
		port_step(r, want);
		status_due.push_back(want);
		@(negedge clk);
	endtask

	// receiver stall, including long hold-offs asked for by the tests
	always @(negedge clk) begin
		if (hold_id != hold_seen) begin
			hold_seen <= hold_id;
			hold_left <= hold_len;
			rsp_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_stall <= 1'b1;
		end else if (stalls_on && $urandom_range(0, 3) == 0) begin
			stall_left <= idle_len();
			rsp_stall <= 1'b1;
		end else
			rsp_stall <= 1'b0;
	end

	task automatic cmp(input string field, input logic [7:0] e, input logic [7:0] a,
			inout bit bad);
		if (e !== a) begin
			if (mismatches < 10)
				$display("mismatch %s: expected %h got %h", field, e, a);
			bad = 1'b1;
		end
	endtask

	task automatic check_rsp(input pcsp_pkg::rsp_t want, input pcsp_pkg::rsp_t got);
		bit bad;
		bad = 1'b0;
		cmp("read_byte", want.read_byte, got.read_byte, bad);
		cmp("rx_not_empty", 8'(want.rx_not_empty), 8'(got.rx_not_empty), bad);
		cmp("tx_ready_started", 8'(want.tx_ready_started), 8'(got.tx_ready_started), bad);
		cmp("tx_ready_finished", 8'(want.tx_ready_finished), 8'(got.tx_ready_finished),
			bad);
		cmp("ack_line_low", 8'(want.ack_line_low), 8'(got.ack_line_low), bad);
		cmp("irq_flag", 8'(want.irq_flag), 8'(got.irq_flag), bad);
		cmp("irq_raise", 8'(want.irq_raise), 8'(got.irq_raise), bad);
		cmp("transfer_start", 8'(want.transfer_start), 8'(got.transfer_start), bad);
		cmp("transfer_byte", want.transfer_byte, got.transfer_byte, bad);
		cmp("transfer_slot", 8'(want.transfer_slot), 8'(got.transfer_slot), bad);
		cmp("ack_wait_device", 8'(want.ack_wait_device), 8'(got.ack_wait_device), bad);
		cmp("deselect_pulse", 8'(want.deselect_pulse), 8'(got.deselect_pulse), bad);
		if (bad)
			mismatches++;
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (status_due.size() == 0) begin
				if (mismatches < 10)
					$display("result with nothing expected: %h", rsp_data);
				mismatches++;
			end else
				check_rsp(status_due.pop_front(), rsp_data);
		end
	end

	function automatic pcsp_pkg::req_t op_req(input logic [2:0] op);
		pcsp_pkg::req_t r;
		r = '0;
		r.operation = op;
		return r;
	endfunction

	function automatic pcsp_pkg::req_t data_req(input logic [7:0] b);
		pcsp_pkg::req_t r;
		r = op_req(pcsp_pkg::OP_WR_DATA);
		r.tx_byte = b;
		return r;
	endfunction

	function automatic pcsp_pkg::req_t ctl_req(input logic sel, input logic txen,
			input logic ack, input logic rst, input logic irqen, input logic slot);
		pcsp_pkg::req_t r;
		r = op_req(pcsp_pkg::OP_WR_CTL);
		r.ctl_select = sel;
		r.ctl_tx_enable = txen;
		r.ctl_acknowledge = ack;
		r.ctl_reset = rst;
		r.ctl_ack_irq_enable = irqen;
		r.ctl_slot = slot;
		return r;
	endfunction

	function automatic pcsp_pkg::req_t xchg_req(input logic pa, input logic [7:0] pr,
			input logic ca, input logic [7:0] cr);
		pcsp_pkg::req_t r;
		r = op_req(pcsp_pkg::OP_XFER_DONE);
		r.pad_acked = pa;
		r.pad_reply = pr;
		r.card_acked = ca;
		r.card_reply = cr;
		return r;
	endfunction

	// guided requests follow the port phase so that transfers run to completion
	function automatic pcsp_pkg::req_t make_request(input bit guided);
		logic [63:0]    raw;
		pcsp_pkg::req_t r;
		int             pick;
		raw = {$urandom, $urandom};
		r = raw[$bits(pcsp_pkg::req_t)-1:0];
		r.ctl_reset = ($urandom_range(0, 7) == 0);
		if (!guided)
			return r;
		pick = $urandom_range(0, 99);
		r.ctl_reset = 1'b0;
		r.pad_acked = ($urandom_range(0, 4) != 0);
		r.card_acked = ($urandom_range(0, 4) != 0);
		if (phase == pcsp_pkg::PH_IDLE) begin
			if (!(sel_bit && txen_bit) || pick < 5) begin
				r.operation = pcsp_pkg::OP_WR_CTL;
				r.ctl_select = ($urandom_range(0, 9) != 0);
				r.ctl_tx_enable = ($urandom_range(0, 9) != 0);
				r.ctl_reset = ($urandom_range(0, 29) == 0);
			end else
				r.operation = (pick < 70) ? pcsp_pkg::OP_WR_DATA : pcsp_pkg::OP_RD_DATA;
		end else if (pick < 8)
			r.operation = pcsp_pkg::OP_RD_DATA;
		else if (pick < 15)
			r.operation = pcsp_pkg::OP_WR_DATA;
		else if (pick < 17)
			r.operation = pcsp_pkg::OP_WR_CTL;
		else case (phase)
			pcsp_pkg::PH_XFER: r.operation = pcsp_pkg::OP_XFER_DONE;
			pcsp_pkg::PH_ACKP: r.operation = pcsp_pkg::OP_ACK_DELAY;
			default: r.operation = pcsp_pkg::OP_ACK_LOW;
		endcase
		return r;
	endfunction

	task automatic test_directed();
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		send_request(op_req(pcsp_pkg::OP_RD_DATA));
		send_request(op_req(pcsp_pkg::OP_ACK_DELAY));
		send_request(op_req(pcsp_pkg::OP_XFER_DONE));
		send_request(data_req(8'h00));
		send_request(data_req(8'hff));
		send_request(ctl_req(1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1));
		send_request(op_req(pcsp_pkg::OP_ACK_LOW));
		send_request(data_req(8'h5a));
		send_request(xchg_req(1'b1, 8'h00, 1'b1, 8'hff));
		send_request(op_req(pcsp_pkg::OP_ACK_DELAY));
		send_request(op_req(pcsp_pkg::OP_ACK_LOW));
		send_request(xchg_req(1'b0, 8'hff, 1'b1, 8'h00));
		send_request(op_req(pcsp_pkg::OP_RD_DATA));
		send_request(op_req(pcsp_pkg::OP_RD_DATA));
		send_request(data_req(8'h80));
		send_request(xchg_req(1'b0, 8'h12, 1'b1, 8'hff));
		send_request(op_req(pcsp_pkg::OP_ACK_DELAY));
		send_request(ctl_req(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
		send_request(op_req(pcsp_pkg::OP_ACK_LOW));
		send_request(op_req(OP_SPARE6));
		send_request(op_req(OP_SPARE7));
		send_request(data_req(8'h33));
		send_request(data_req(8'h44));
		send_request(xchg_req(1'b0, 8'hff, 1'b0, 8'hff));
		send_request(ctl_req(1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0));
		send_request(ctl_req(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
	endtask

	task automatic test_back_to_back();
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		repeat (120)
			send_request(make_request($urandom_range(0, 9) != 0));
	endtask

	task automatic test_backpressure();
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		hold_len = 80;
		hold_id++;
		repeat (40)
			send_request(make_request(1'b1));
		stalls_on = 1'b1;
		repeat (20)
			send_request(make_request(1'b1));
	endtask

	task automatic test_random();
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		repeat (700)
			send_request(make_request($urandom_range(0, 99) < 85));
		gaps_on = 1'b0;
		stalls_on = 1'b0;
	endtask

	initial begin
		int drain;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_back_to_back();
		test_backpressure();
		test_random();
		req_valid <= 1'b0;
		drain = 0;
		while (status_due.size() != 0 && drain < 5000) begin
			@(posedge clk);
			drain++;
		end
		repeat (8) @(posedge clk);
		errors += status_due.size();
		if (errors == 0 && mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

endmodule
